@@ src/pulse_period_histogram_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the pulse period histogram checker
// ---------------------------------------------------------------------------
`ifndef PULSE_PERIOD_HISTOGRAM_DEFINES_SVH
`define PULSE_PERIOD_HISTOGRAM_DEFINES_SVH

// Consequent in the same cycle, checked outside reset.
`define PHH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the next cycle, checked outside reset.
`define PHH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Behaviour in the cycle after a reset cycle.
`define PHH_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

@@ src/phh_pkg.sv @@
// ---------------------------------------------------------------------------
// phh_pkg
// Widths, codes and shared types of the pulse period histogram.
// ---------------------------------------------------------------------------
package phh_pkg;

  localparam int BINS       = 101;
  localparam int BIN_W      = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 7;
  localparam int LL_W       = 14;
  localparam int ST_W       = 16;
  localparam int PERIOD_W   = 32;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [LL_W-1:0] LL_RESET = LL_W'(950);
  localparam logic [ST_W-1:0] ST_RESET = ST_W'(1000);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_LIMIT   = 1'b0,
    REG_SAMPLE_TARGET = 1'b1
  } cfg_reg_t;

  // Histogram access requested by the control stage
  typedef struct packed {
    logic             clear;
    logic             inc;
    logic             rd;
    logic [BIN_W-1:0] addr;
  } phh_lookup_t;

  // Period and run status of one transaction
  typedef struct packed {
    logic [PERIOD_W-1:0] period_us;
    logic                period_valid;
    logic                in_window;
    logic                run_done;
  } phh_status_t;

endpackage

@@ src/phh_item_if.sv @@
// ---------------------------------------------------------------------------
// phh_item_if
// Input channel: operation, pin sample and bin index with valid/ready.
// ---------------------------------------------------------------------------
interface phh_item_if;
  import phh_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic             pin_level;
  logic [IDX_W-1:0] bin_index;

  modport source (output valid, output operation, output pin_level, output bin_index,
                  input ready);
  modport sink   (input valid, input operation, input pin_level, input bin_index,
                  output ready);
endinterface

@@ src/phh_result_if.sv @@
// ---------------------------------------------------------------------------
// phh_result_if
// Result channel: measured period, flags and bin count with valid/ready.
// ---------------------------------------------------------------------------
interface phh_result_if;
  import phh_pkg::*;

  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] period_us;
  logic                period_valid;
  logic                in_window;
  logic                run_done;
  logic [CNT_W-1:0]    bin_count;

  modport source (output valid, output period_us, output period_valid, output in_window,
                  output run_done, output bin_count, input ready);
  modport sink   (input valid, input period_us, input period_valid, input in_window,
                  input run_done, input bin_count, output ready);
endinterface

@@ src/phh_ctrl.sv @@
// ---------------------------------------------------------------------------
// phh_ctrl
// Edge detection, period timing and run control for one transaction.
// ---------------------------------------------------------------------------
module phh_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            s1_valid,
  input  logic [phh_pkg::OP_W-1:0]        operation,
  input  logic                            pin_level,
  input  logic [phh_pkg::IDX_W-1:0]       bin_index,
  input  logic [phh_pkg::LL_W-1:0]        lower_limit,
  input  logic [phh_pkg::ST_W-1:0]        sample_target,
  output phh_pkg::phh_lookup_t            lookup,
  output phh_pkg::phh_status_t            status
);
  import phh_pkg::*;

  logic                seen_low, seen_low_next;
  logic                waiting, waiting_next;
  logic                running, running_next;
  // elapsed tracks tick clock minus edge start time
  logic [PERIOD_W-1:0] elapsed, elapsed_next;
  logic [ST_W-1:0]     periods_done, periods_done_next;

  logic [PERIOD_W-1:0] offset;
  logic                in_range;
  logic [ST_W-1:0]     done_inc;

  assign offset   = elapsed - PERIOD_W'(lower_limit);
  assign in_range = (elapsed >= PERIOD_W'(lower_limit)) && (offset < PERIOD_W'(BINS));
  assign done_inc = periods_done + ST_W'(1);

  always_comb begin
    seen_low_next       = seen_low;
    waiting_next        = waiting;
    running_next        = running;
    elapsed_next        = elapsed;
    periods_done_next   = periods_done;
    lookup              = '0;
    status.period_us    = '0;
    status.period_valid = 1'b0;
    status.in_window    = 1'b0;
    case (op_t'(operation))
      OP_TICK: begin
        if (running) begin
          elapsed_next = elapsed + PERIOD_W'(1);
          if (seen_low && pin_level) begin
            seen_low_next = 1'b0;
            if (!waiting) begin
              waiting_next = 1'b1;
              elapsed_next = PERIOD_W'(1);
            end else begin
              waiting_next        = 1'b0;
              status.period_us    = elapsed;
              status.period_valid = 1'b1;
              if (in_range) begin
                status.in_window = 1'b1;
                lookup.inc       = 1'b1;
                lookup.addr      = offset[BIN_W-1:0];
              end
              periods_done_next = done_inc;
              if (done_inc >= sample_target) begin
                running_next = 1'b0;
              end
            end
          end else if (!pin_level) begin
            seen_low_next = 1'b1;
          end
        end
      end
      OP_START: begin
        seen_low_next     = 1'b0;
        waiting_next      = 1'b0;
        running_next      = 1'b1;
        elapsed_next      = '0;
        periods_done_next = '0;
        lookup.clear      = 1'b1;
      end
      OP_READ: begin
        if (int'(bin_index) < BINS) begin
          lookup.rd   = 1'b1;
          lookup.addr = BIN_W'(bin_index);
        end
      end
      default: begin
      end
    endcase
    status.run_done = !running_next && (periods_done_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_low     <= 1'b0;
      waiting      <= 1'b0;
      running      <= 1'b0;
      elapsed      <= '0;
      periods_done <= '0;
    end else if (advance && s1_valid) begin
      seen_low     <= seen_low_next;
      waiting      <= waiting_next;
      running      <= running_next;
      elapsed      <= elapsed_next;
      periods_done <= periods_done_next;
    end
  end

endmodule

@@ src/phh_store.sv @@
// ---------------------------------------------------------------------------
// phh_store
// Histogram memory with per-bin valid bits, read-modify-write and bypass.
// ---------------------------------------------------------------------------
module phh_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         s1_valid,
  input  logic                         s2_valid,
  input  phh_pkg::phh_lookup_t         lookup,
  output logic [phh_pkg::CNT_W-1:0]    bin_count
);
  import phh_pkg::*;

  logic [CNT_W-1:0] mem [BINS];
  logic [BINS-1:0]  bin_valid;

  phh_lookup_t      s2_lookup;
  logic [CNT_W-1:0] mem_q;
  logic             valid_q;
  logic             fwd_hit;
  logic [CNT_W-1:0] fwd_data;

  logic [CNT_W-1:0] current;
  logic [CNT_W-1:0] wdata;
  logic             wr_en;

  // bypass a write to the same bin made in the cycle of the read
  assign current = fwd_hit ? fwd_data : (valid_q ? mem_q : '0);
  assign wdata   = current + CNT_W'(1);
  assign wr_en   = advance && s2_valid && s2_lookup.inc;

  assign bin_count = s2_lookup.rd ? current : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s2_lookup.addr] <= wdata;
    end
    if (advance) begin
      mem_q <= mem[lookup.addr];
    end
  end

  // a start clears every bin at once; it wins over an older increment
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (advance && s1_valid && lookup.clear) begin
      bin_valid <= '0;
    end else if (wr_en) begin
      bin_valid[s2_lookup.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_lookup <= lookup;
      valid_q   <= bin_valid[lookup.addr];
      fwd_hit   <= wr_en && (s2_lookup.addr == lookup.addr);
      fwd_data  <= wdata;
    end
  end

endmodule

@@ src/pulse_period_histogram.sv @@
// ---------------------------------------------------------------------------
// pulse_period_histogram
// Rising-edge period meter with a windowed histogram of the periods.
// ---------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   cfg       in   cfg_write      cfg_index, cfg_data
//   item      in   valid/ready    operation, pin_level, bin_index
//   result    out  valid/ready    period_us, period_valid, in_window,
//                                 run_done, bin_count
//
// One transaction is accepted per cycle while the result is not stalled;
// its result is presented from the last of three register stages (input
// register, histogram read register, output register).
// The histogram read-modify-write spans the first two stages, with a bypass
// so consecutive transactions on one bin see each other.
// Reset is synchronous; no clearing pass is needed, as per-bin valid bits
// reset (and a start transaction clears) at once.
// A stalled result holds the whole pipeline; ready drops only then.
// ---------------------------------------------------------------------------
module pulse_period_histogram (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [phh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [phh_pkg::CFG_DATA_W-1:0]    cfg_data,
  phh_item_if.sink                          item,
  phh_result_if.source                      result
);
  import phh_pkg::*;

  // configuration registers
  logic [LL_W-1:0] lower_limit;
  logic [ST_W-1:0] sample_target;

  // pipeline control
  logic advance;
  logic s1_valid;
  logic s2_valid;
  logic out_valid;

  // input register
  logic [OP_W-1:0]  s1_operation;
  logic             s1_pin_level;
  logic [IDX_W-1:0] s1_bin_index;

  phh_lookup_t      lookup;
  phh_status_t      s1_status;
  phh_status_t      s2_status;
  logic [CNT_W-1:0] s2_bin_count;

  // output register
  phh_status_t      out_status;
  logic [CNT_W-1:0] out_bin_count;

  // Advance every stage unless the result waits untaken.
  assign advance    = !(out_valid && !result.ready);
  assign item.ready = advance;

  // Hold the configuration; the user must land a write between transactions, unenforced by the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit   <= LL_RESET;
      sample_target <= ST_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOWER_LIMIT:   lower_limit   <= cfg_data[LL_W-1:0];
        REG_SAMPLE_TARGET: sample_target <= cfg_data[ST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= item.valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Capture the transaction payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_operation <= item.operation;
      s1_pin_level <= item.pin_level;
      s1_bin_index <= item.bin_index;
    end
  end

  // Stage one: edge detection, timing and window test; issue the bin read.
  phh_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .s1_valid      (s1_valid),
    .operation     (s1_operation),
    .pin_level     (s1_pin_level),
    .bin_index     (s1_bin_index),
    .lower_limit   (lower_limit),
    .sample_target (sample_target),
    .lookup        (lookup),
    .status        (s1_status)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_status <= s1_status;
    end
  end

  // Stage two: bin count out, incremented count written back.
  phh_store u_store (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s2_valid  (s2_valid),
    .lookup    (lookup),
    .bin_count (s2_bin_count)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status    <= s2_status;
      out_bin_count <= s2_bin_count;
    end
  end

  assign result.valid        = out_valid;
  assign result.period_us    = out_status.period_us;
  assign result.period_valid = out_status.period_valid;
  assign result.in_window    = out_status.in_window;
  assign result.run_done     = out_status.run_done;
  assign result.bin_count    = out_bin_count;

endmodule

@@ src/phh_checker.sv @@
// ---------------------------------------------------------------------------
// phh_checker
// Port-level checks on the pulse period histogram, bound to the top level.
// ---------------------------------------------------------------------------
`include "pulse_period_histogram_defines.svh"

module phh_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [phh_pkg::PERIOD_W-1:0]   result_period_us,
  input logic                           result_period_valid,
  input logic                           result_in_window,
  input logic [phh_pkg::CNT_W-1:0]      result_bin_count
);
  import phh_pkg::*;

  `PHH_ASSERT_RESET(a_reset_empty, !result_valid, "result valid after reset")

  `PHH_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready,
    result_valid && $stable(result_period_us) && $stable(result_bin_count),
    "stalled result changed")

  `PHH_ASSERT_SAME(a_ready_when_empty, !result_valid, item_ready,
    "input not ready with empty output")

  `PHH_ASSERT_SAME(a_no_period_fields,
    result_valid && !result_period_valid,
    (result_period_us == '0) && !result_in_window,
    "period fields set without a period")

  `PHH_ASSERT_SAME(a_period_no_count, result_valid && result_period_valid,
    result_bin_count == '0, "bin count set on a period result")

endmodule

bind pulse_period_histogram phh_checker u_phh_checker (
  .clk                 (clk),
  .rst                 (rst),
  .item_ready          (item.ready),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_period_us    (result.period_us),
  .result_period_valid (result.period_valid),
  .result_in_window    (result.in_window),
  .result_bin_count    (result.bin_count)
);
